// ----- rtl/core/lkv_pkg.sv -----
// -----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants of the key-value cache with LRU replacement.
// -----------------------------------------------------------------------------
package lkv_pkg;

   localparam int KEY_W = 32;
   localparam int VAL_W = 32;
   localparam int CAP_W = 5;

   // Request opcodes.
   localparam logic OP_GET = 1'b0;
   localparam logic OP_SET = 1'b1;

   // Value returned by a get that misses.
   localparam logic [VAL_W-1:0] MISS_VALUE = '1;

   // Capacity after reset.
   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_PLAN,
      ST_UPDATE,
      ST_DONE
   } state_type;

endpackage

// ----- rtl/core/lkv_ram.sv -----
// -----------------------------------------------------------------------------
// lkv_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// -----------------------------------------------------------------------------
module lkv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   parameter int ADDR_W = 4
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/lkv_scan.sv -----
// -----------------------------------------------------------------------------
// lkv_scan
// Search unit: takes one stored entry per cycle while step is high and keeps
// the matching entry, the least recent valid entry and the first unused slot.
// -----------------------------------------------------------------------------
module lkv_scan #(
   parameter int ENTRIES = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic                       step,
   input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] step_idx,
   input  logic                       step_used,
   input  logic [lkv_pkg::KEY_W-1:0]  step_key,
   input  logic [lkv_pkg::VAL_W-1:0]  step_value,
   input  logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] step_rank,
   input  logic [lkv_pkg::KEY_W-1:0]  lookup_key,
   output logic                       hit,
   output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] hit_idx,
   output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] hit_rank,
   output logic [lkv_pkg::VAL_W-1:0]  hit_value,
   output logic                       old_found,
   output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] old_idx,
   output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] old_rank,
   output logic                       free_found,
   output logic [(ENTRIES > 1 ? $clog2(ENTRIES) : 1)-1:0] free_idx
);
   import lkv_pkg::*;

   localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

   logic          hit_ff, hit_in;
   logic [IW-1:0] hit_idx_ff, hit_idx_in;
   logic [IW-1:0] hit_rank_ff, hit_rank_in;
   logic [VAL_W-1:0] hit_value_ff, hit_value_in;
   logic          old_found_ff, old_found_in;
   logic [IW-1:0] old_idx_ff, old_idx_in;
   logic [IW-1:0] old_rank_ff, old_rank_in;
   logic          free_found_ff, free_found_in;
   logic [IW-1:0] free_idx_ff, free_idx_in;

   always_comb begin
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      hit_rank_in   = hit_rank_ff;
      hit_value_in  = hit_value_ff;
      old_found_in  = old_found_ff;
      old_idx_in    = old_idx_ff;
      old_rank_in   = old_rank_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      if (clear) begin
         hit_in        = 1'b0;
         old_found_in  = 1'b0;
         free_found_in = 1'b0;
      end else if (step) begin
         // The first match wins, as does the first unused slot.
         if (step_used && step_key == lookup_key && !hit_ff) begin
            hit_in       = 1'b1;
            hit_idx_in   = step_idx;
            hit_rank_in  = step_rank;
            hit_value_in = step_value;
         end
         if (step_used && (!old_found_ff || step_rank > old_rank_ff)) begin
            old_found_in = 1'b1;
            old_idx_in   = step_idx;
            old_rank_in  = step_rank;
         end
         if (!step_used && !free_found_ff) begin
            free_found_in = 1'b1;
            free_idx_in   = step_idx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff        <= 1'b0;
         old_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
      end else begin
         hit_ff        <= hit_in;
         old_found_ff  <= old_found_in;
         free_found_ff <= free_found_in;
      end
      hit_idx_ff   <= hit_idx_in;
      hit_rank_ff  <= hit_rank_in;
      hit_value_ff <= hit_value_in;
      old_idx_ff   <= old_idx_in;
      old_rank_ff  <= old_rank_in;
      free_idx_ff  <= free_idx_in;
   end

   assign hit        = hit_ff;
   assign hit_idx    = hit_idx_ff;
   assign hit_rank   = hit_rank_ff;
   assign hit_value  = hit_value_ff;
   assign old_found  = old_found_ff;
   assign old_idx    = old_idx_ff;
   assign old_rank   = old_rank_ff;
   assign free_found = free_found_ff;
   assign free_idx   = free_idx_ff;

endmodule

// ----- rtl/core/lru_key_value_cache.sv -----
// -----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// -----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Payload
//   req_      in         req_valid/req_stall  opcode, lookup_key, write_value
//   rsp_      out        rsp_valid/rsp_stall  hit, read_value
//   csr_      in         csr_wr_en            capacity_in_use (5 bits)
//
// A get that misses makes only a search pass over the entry RAM, which has one
// read and one write port; every other request makes a search pass and then a
// rank update pass before its result is presented.
// Reset clears the valid flags, the occupancy count and the control state;
// the RAM itself needs no clearing pass. A finished result waits in the output
// register while a new request is taken; only the hand-over of the next result
// waits for that register to be free.
//
module lru_key_value_cache #(
   parameter int ENTRIES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic signed [lkv_pkg::KEY_W-1:0]  req_lookup_key,
   input  logic signed [lkv_pkg::VAL_W-1:0]  req_write_value,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_hit,
   output logic signed [lkv_pkg::VAL_W-1:0]  rsp_read_value,
   input  logic                              csr_wr_en,
   input  logic [lkv_pkg::CAP_W-1:0]         csr_wr_data
);
   import lkv_pkg::*;

   // Slot index and rank share one width: ranks run from 0 to ENTRIES - 1.
   localparam int IW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);
   localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
   localparam int DW    = KEY_W + VAL_W + IW;
   localparam logic [IW-1:0]    LAST_IDX = IW'(ENTRIES - 1);
   localparam logic [IW:0]      PTR_END  = (IW + 1)'(ENTRIES);
   localparam logic [CMP_W-1:0] CAP_MAX  = CMP_W'(ENTRIES);

   state_type state_ff, state_in;

   logic [CAP_W-1:0]   cap_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;

   logic               req_op_ff, req_op_in;
   logic [KEY_W-1:0]   req_key_ff, req_key_in;
   logic [VAL_W-1:0]   req_value_ff, req_value_in;

   // Pass sequencing: ptr issues RAM reads, chk marks the entry returned.
   logic [IW:0]        ptr_ff, ptr_in;
   logic               chk_ff, chk_in;
   logic [IW-1:0]      chk_idx_ff, chk_idx_in;

   // Plan for the update pass.
   logic [IW-1:0]      slot_ff, slot_in;
   logic [IW-1:0]      thresh_ff, thresh_in;
   logic               age_all_ff, age_all_in;
   logic               write_kv_ff, write_kv_in;
   logic               res_hit_ff, res_hit_in;
   logic [VAL_W-1:0]   res_value_ff, res_value_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_hit_ff, rsp_hit_in;
   logic [VAL_W-1:0]   rsp_value_ff, rsp_value_in;

   logic               rd_en;
   logic [IW-1:0]      rd_addr;
   logic [DW-1:0]      rd_data;
   logic               wr_en;
   logic [IW-1:0]      wr_addr;
   logic [DW-1:0]      wr_data;

   logic               scan_clear;
   logic               sc_hit, sc_old_found, sc_free_found;
   logic [IW-1:0]      sc_hit_idx, sc_hit_rank, sc_old_idx, sc_old_rank, sc_free_idx;
   logic [VAL_W-1:0]   sc_hit_value;

   logic               req_xfer;
   logic               rsp_xfer;
   logic               issue;
   logic               last_chk;
   logic               out_free;
   logic [CMP_W-1:0]   cap_ext;
   logic [CMP_W-1:0]   cap_eff;
   logic               room;

   logic [KEY_W-1:0]   old_key;
   logic [VAL_W-1:0]   old_value;
   logic [IW-1:0]      old_rank;

   assign req_xfer = req_valid && !req_stall;
   assign rsp_xfer = rsp_valid_ff && !rsp_stall;
   assign issue    = ptr_ff < PTR_END;
   assign last_chk = chk_ff && (chk_idx_ff == LAST_IDX);
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // A capacity of zero behaves as one, any above the entry count as full size.
   assign cap_ext = CMP_W'(cap_ff);
   always_comb begin
      priority if (cap_ext == '0) begin
         cap_eff = CMP_W'(1);
      end else if (cap_ext > CAP_MAX) begin
         cap_eff = CAP_MAX;
      end else begin
         cap_eff = cap_ext;
      end
   end
   assign room = CMP_W'(count_ff) < cap_eff;

   // RAM word layout: key, value, rank.
   assign old_key   = rd_data[DW-1 -: KEY_W];
   assign old_value = rd_data[IW +: VAL_W];
   assign old_rank  = rd_data[IW-1:0];

   lkv_ram #(
      .WIDTH  (DW),
      .DEPTH  (ENTRIES),
      .ADDR_W (IW)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lkv_scan #(
      .ENTRIES (ENTRIES)
   ) u_scan (
      .clock      (clock),
      .reset      (reset),
      .clear      (scan_clear),
      .step       (chk_ff && state_ff == ST_SCAN),
      .step_idx   (chk_idx_ff),
      .step_used  (valid_ff[chk_idx_ff]),
      .step_key   (old_key),
      .step_value (old_value),
      .step_rank  (old_rank),
      .lookup_key (req_key_ff),
      .hit        (sc_hit),
      .hit_idx    (sc_hit_idx),
      .hit_rank   (sc_hit_rank),
      .hit_value  (sc_hit_value),
      .old_found  (sc_old_found),
      .old_idx    (sc_old_idx),
      .old_rank   (sc_old_rank),
      .free_found (sc_free_found),
      .free_idx   (sc_free_idx)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (last_chk) begin
               state_in = ST_PLAN;
            end
         end
         ST_PLAN: begin
            // A get that misses changes nothing and skips the update pass.
            if (req_op_ff == OP_GET && !sc_hit) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (last_chk) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and outputs.
   always_comb begin
      req_op_in    = req_op_ff;
      req_key_in   = req_key_ff;
      req_value_in = req_value_ff;
      ptr_in       = ptr_ff;
      chk_in       = 1'b0;
      chk_idx_in   = ptr_ff[IW-1:0];
      slot_in      = slot_ff;
      thresh_in    = thresh_ff;
      age_all_in   = age_all_ff;
      write_kv_in  = write_kv_ff;
      res_hit_in   = res_hit_ff;
      res_value_in = res_value_ff;
      valid_in     = valid_ff;
      count_in     = count_ff;
      scan_clear   = 1'b0;
      rd_en        = 1'b0;
      rd_addr      = ptr_ff[IW-1:0];
      wr_en        = 1'b0;
      wr_addr      = chk_idx_ff;
      wr_data      = rd_data;
      rsp_valid_in = rsp_xfer ? 1'b0 : rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_value_in = rsp_value_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               req_op_in    = req_opcode;
               req_key_in   = unsigned'(req_lookup_key);
               req_value_in = unsigned'(req_write_value);
               ptr_in       = '0;
               scan_clear   = 1'b1;
            end
         end
         ST_SCAN: begin
            rd_en  = issue;
            chk_in = issue;
            if (issue) begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_PLAN: begin
            ptr_in      = '0;
            age_all_in  = 1'b0;
            write_kv_in = (req_op_ff == OP_SET);
            if (sc_hit) begin
               // Present key: it moves to the front, younger entries age.
               slot_in      = sc_hit_idx;
               thresh_in    = sc_hit_rank;
               res_hit_in   = 1'b1;
               res_value_in = (req_op_ff == OP_SET) ? req_value_ff : sc_hit_value;
            end else if (req_op_ff == OP_GET) begin
               res_hit_in   = 1'b0;
               res_value_in = MISS_VALUE;
            end else begin
               res_hit_in   = 1'b0;
               res_value_in = req_value_ff;
               priority if (room && sc_free_found) begin
                  // Insertion into an unused slot: every valid entry ages.
                  slot_in           = sc_free_idx;
                  age_all_in        = 1'b1;
                  valid_in[sc_free_idx] = 1'b1;
                  count_in          = count_ff + 1'b1;
               end else if (sc_old_found) begin
                  // Eviction: the least recent entry is reused in place.
                  slot_in   = sc_old_idx;
                  thresh_in = sc_old_rank;
               end else begin
                  // Nothing valid at all: slot zero becomes the first entry.
                  slot_in     = '0;
                  age_all_in  = 1'b1;
                  valid_in[0] = 1'b1;
                  count_in    = CNT_W'(1);
               end
            end
         end
         ST_UPDATE: begin
            // Read one entry ahead of the write; the two never share an address.
            rd_en  = issue;
            chk_in = issue;
            if (issue) begin
               ptr_in = ptr_ff + 1'b1;
            end
            wr_en = chk_ff;
            if (chk_idx_ff == slot_ff) begin
               wr_data = {write_kv_ff ? req_key_ff : old_key,
                          write_kv_ff ? req_value_ff : old_value,
                          {IW{1'b0}}};
            end else if (valid_ff[chk_idx_ff] && (age_all_ff || old_rank < thresh_ff)) begin
               wr_data = {old_key, old_value, IW'(old_rank + 1'b1)};
            end else begin
               wr_data = rd_data;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               rsp_value_in = res_value_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         valid_ff     <= '0;
         ptr_ff       <= '0;
         chk_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         count_ff     <= count_in;
         valid_ff     <= valid_in;
         ptr_ff       <= ptr_in;
         chk_ff       <= chk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      req_op_ff    <= req_op_in;
      req_key_ff   <= req_key_in;
      req_value_ff <= req_value_in;
      chk_idx_ff   <= chk_idx_in;
      slot_ff      <= slot_in;
      thresh_ff    <= thresh_in;
      age_all_ff   <= age_all_in;
      write_kv_ff  <= write_kv_in;
      res_hit_ff   <= res_hit_in;
      res_value_ff <= res_value_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hit        = rsp_hit_ff;
   assign rsp_read_value = signed'(rsp_value_ff);

endmodule

// ----- bench/lkv_checker.sv -----
// -----------------------------------------------------------------------------
// lkv_checker
// Watches the request, reply and register ports of the LRU key-value cache,
// predicts every reply and compares each accepted reply with the oldest one due.
// -----------------------------------------------------------------------------
module lkv_checker #(
   parameter int ENTRIES = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   input  logic                              req_stall,
   input  logic                              req_opcode,
   input  logic signed [lkv_pkg::KEY_W-1:0]  req_lookup_key,
   input  logic signed [lkv_pkg::VAL_W-1:0]  req_write_value,
   input  logic                              rsp_valid,
   input  logic                              rsp_stall,
   input  logic                              rsp_hit,
   input  logic signed [lkv_pkg::VAL_W-1:0]  rsp_read_value,
   input  logic                              csr_wr_en,
   input  logic [lkv_pkg::CAP_W-1:0]         csr_wr_data,
   output int                                mismatch_count,
   output int                                replies_outstanding,
   output int                                replies_checked,
   output int                                hits_seen
);

   import lkv_pkg::*;

   typedef struct packed {
      logic             hit;
      logic [VAL_W-1:0] value;
   } reply_type;

   reply_type        due_replies[$];

   logic [KEY_W-1:0] slot_key   [ENTRIES];
   logic [VAL_W-1:0] slot_value [ENTRIES];
   bit               slot_valid [ENTRIES];
   int unsigned      slot_rank  [ENTRIES];
   int unsigned      occupancy;
   logic [CAP_W-1:0] capacity;

   function automatic int unsigned usable_capacity();
      int unsigned c;
      c = 32'(capacity);
      if (c < 1) c = 1;
      if (c > ENTRIES) c = ENTRIES;
      return c;
   endfunction

   // Slot s becomes the most recent; every entry that was more recent ages by one.
   task automatic promote(input int s);
      int unsigned r;
      r = slot_rank[s];
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_valid[i] && i != s && slot_rank[i] < r) slot_rank[i]++;
      end
      slot_rank[s] = 0;
   endtask

   task automatic cache_access(input logic op, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] val, output reply_type reply);
      int found;
      int slot;
      found = -1;
      slot  = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (found < 0 && slot_valid[i] && slot_key[i] == key) found = i;
      end
      if (op == OP_GET) begin
         if (found >= 0) begin
            promote(found);
            reply = '{hit: 1'b1, value: slot_value[found]};
         end else begin
            reply = '{hit: 1'b0, value: MISS_VALUE};
         end
      end else if (found >= 0) begin
         promote(found);
         slot_value[found] = val;
         reply = '{hit: 1'b1, value: val};
      end else begin
         if (occupancy < usable_capacity()) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot < 0 && !slot_valid[i]) slot = i;
            end
         end
         if (slot >= 0) begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_valid[i]) slot_rank[i]++;
            end
            slot_valid[slot] = 1'b1;
            slot_rank[slot]  = 0;
            occupancy++;
         end else begin
            for (int i = 0; i < ENTRIES; i++) begin
               if (slot_valid[i] && (slot < 0 || slot_rank[i] > slot_rank[slot])) slot = i;
            end
            if (slot < 0) begin
               slot = 0;
               slot_valid[0] = 1'b1;
               slot_rank[0]  = 0;
               occupancy     = 1;
            end else begin
               promote(slot);
            end
         end
         slot_key[slot]   = key;
         slot_value[slot] = val;
         reply = '{hit: 1'b0, value: val};
      end
   endtask

   task automatic report_mismatch(input string text);
      $display("MISMATCH at %0t: %s", $realtime, text);
      mismatch_count++;
   endtask

   always @(posedge clock) begin
      reply_type due;
      reply_type predicted;
      if (reset) begin
         for (int i = 0; i < ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_rank[i]  = 0;
         end
         occupancy = 0;
         capacity  = CAP_RESET;
         due_replies.delete();
         replies_outstanding <= 0;
      end else begin
         if (csr_wr_en) capacity = csr_wr_data;
         // Replies are checked before the request of the same edge is predicted,
         // so that a reply can never be matched against its own request.
         if (rsp_valid && !rsp_stall) begin
            if (due_replies.size() == 0) begin
               report_mismatch($sformatf("reply with none due, hit %b value %h",
                                         rsp_hit, rsp_read_value));
            end else begin
               due = due_replies.pop_front();
               if (rsp_hit !== due.hit)
                  report_mismatch($sformatf("reply %0d hit %b, expected %b",
                                            replies_checked, rsp_hit, due.hit));
               if (rsp_read_value !== due.value)
                  report_mismatch($sformatf("reply %0d read_value %h, expected %h",
                                            replies_checked, rsp_read_value, due.value));
               if (due.hit) hits_seen++;
            end
            replies_checked++;
         end
         if (req_valid && !req_stall) begin
            cache_access(req_opcode, req_lookup_key, req_write_value, predicted);
            due_replies.push_back(predicted);
         end
         replies_outstanding <= due_replies.size();
      end
   end

endmodule

// ----- bench/testbench.sv -----
// -----------------------------------------------------------------------------
// testbench
// Drives the LRU key-value cache with a directed opening and random get/set
// traffic over a range of capacities and idling patterns; the checker judges.
// -----------------------------------------------------------------------------
module testbench;

   import lkv_pkg::*;

   localparam int ENTRIES    = 16;
   localparam int POOL_SIZE  = 20;
   localparam int PHASES     = 10;
   localparam int PHASE_LEN  = 60;
   // Capacities visited by the random phases: zero and values above the entry
   // count are included so that clamping and saturation are both exercised.
   localparam int PHASE_CAPS [PHASES] = '{16, 1, 4, 31, 0, 8, 3, 20, 2, 16};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic                      req_opcode = OP_GET;
   logic signed [KEY_W-1:0]   req_lookup_key = '0;
   logic signed [VAL_W-1:0]   req_write_value = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_hit;
   logic signed [VAL_W-1:0]   rsp_read_value;
   logic                      csr_wr_en = 1'b0;
   logic [CAP_W-1:0]          csr_wr_data = '0;

   int                        mismatch_count;
   int                        replies_outstanding;
   int                        replies_checked;
   int                        hits_seen;

   // Percentages of cycles in which the sender holds back and the receiver stalls.
   int                        idle_pct  = 0;
   int                        stall_pct = 0;
   int                        requests_sent = 0;
   logic [KEY_W-1:0]          key_pool [POOL_SIZE];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   lru_key_value_cache #(
      .ENTRIES(ENTRIES)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_opcode     (req_opcode),
      .req_lookup_key (req_lookup_key),
      .req_write_value(req_write_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_hit        (rsp_hit),
      .rsp_read_value (rsp_read_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   lkv_checker #(
      .ENTRIES(ENTRIES)
   ) u_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_opcode         (req_opcode),
      .req_lookup_key     (req_lookup_key),
      .req_write_value    (req_write_value),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit            (rsp_hit),
      .rsp_read_value     (rsp_read_value),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data),
      .mismatch_count     (mismatch_count),
      .replies_outstanding(replies_outstanding),
      .replies_checked    (replies_checked),
      .hits_seen          (hits_seen)
   );

   // The receiver draws a fresh stall decision every cycle, so stalls land on
   // every phase of a reply's presentation.
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Offers one request and holds it, unchanged, until the transfer takes place.
   // Any idle cycles come first, so valid is never lowered and raised in one step.
   task automatic send_request(input logic op, input logic [KEY_W-1:0] key,
                               input logic [VAL_W-1:0] val);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_lookup_key  <= key;
      req_write_value <= val;
      do @(posedge clock); while (req_stall);
      requests_sent++;
   endtask

   // Stops offering requests until every predicted reply has been transferred,
   // then lets the block settle back into its idle state.
   task automatic drain_replies();
      req_valid <= 1'b0;
      @(posedge clock);
      while (replies_outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // The capacity register is only written while the block has nothing in hand.
   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      drain_replies();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   initial begin
      int   eff;
      int   span;
      logic op;
      logic [KEY_W-1:0] key;

      // Extreme keys sit in the pool beside random ones so that random traffic
      // keeps hitting them as well.
      key_pool[0] = 32'h8000_0000;
      key_pool[1] = 32'h7FFF_FFFF;
      key_pool[2] = 32'h0000_0000;
      key_pool[3] = 32'hFFFF_FFFF;
      for (int i = 4; i < POOL_SIZE; i++) key_pool[i] = $urandom;

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed opening at the reset capacity: a lookup in an empty cache,
      // inserts of extreme keys and values, hits, a miss and an update.
      send_request(OP_GET, 32'h0000_0000, 32'h1234_5678);
      send_request(OP_SET, 32'h8000_0000, 32'h7FFF_FFFF);
      send_request(OP_SET, 32'h7FFF_FFFF, 32'h8000_0000);
      send_request(OP_SET, 32'h0000_0000, 32'h0000_0000);
      send_request(OP_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
      // A stored value of all ones must come back with hit set.
      send_request(OP_GET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      send_request(OP_GET, 32'h1234_5678, 32'hFFFF_FFFF);
      send_request(OP_SET, 32'h7FFF_FFFF, 32'h0000_0000);
      send_request(OP_GET, 32'h7FFF_FFFF, 32'hAAAA_AAAA);

      // Capacity lowered below the number of entries held: a new key must
      // reuse the least recent slot while the count stays where it is.
      write_capacity(5'd2);
      send_request(OP_SET, 32'h5555_5555, 32'hAAAA_AAAA);
      send_request(OP_GET, 32'h0000_0000, 32'h0000_0000);
      send_request(OP_GET, 32'h8000_0000, 32'h0000_0000);
      send_request(OP_SET, 32'hAAAA_AAAA, 32'h5555_5555);

      // A capacity of zero behaves as a capacity of one.
      write_capacity(5'd0);
      send_request(OP_SET, 32'h0000_0001, 32'h0000_0001);
      send_request(OP_GET, 32'h0000_0001, 32'h0000_0000);
      send_request(OP_GET, 32'h5555_5555, 32'h0000_0000);

      // A capacity beyond the entry count saturates at the entry count.
      write_capacity(5'd31);
      send_request(OP_SET, 32'h0000_0002, 32'h0000_0002);
      send_request(OP_GET, 32'h0000_0002, 32'h0000_0000);
      send_request(OP_GET, 32'h7FFF_FFFF, 32'h0000_0000);

      // Random phases: each picks a capacity and an idling pattern. Most keys
      // come from a pool a little larger than the capacity, so that hits,
      // updates and evictions all happen often; the rest are fully random.
      for (int phase = 0; phase < PHASES; phase++) begin
         write_capacity(CAP_W'(PHASE_CAPS[phase]));
         eff = PHASE_CAPS[phase];
         if (eff < 1) eff = 1;
         if (eff > ENTRIES) eff = ENTRIES;
         span = eff + 3;
         if (span > POOL_SIZE) span = POOL_SIZE;
         case (phase % 4)
            0: begin
               idle_pct  = 0;
               stall_pct = 0;
            end
            1: begin
               idle_pct  = 53;
               stall_pct = 0;
            end
            2: begin
               idle_pct  = 0;
               stall_pct = 53;
            end
            default: begin
               idle_pct  = 22;
               stall_pct = 22;
            end
         endcase
         for (int n = 0; n < PHASE_LEN; n++) begin
            // Once, halfway through a phase, the sender waits for every reply.
            if (phase == 5 && n == PHASE_LEN / 2) drain_replies();
            op = 1'($urandom_range(1));
            if ($urandom_range(99) < 80) key = key_pool[$urandom_range(span - 1)];
            else key = $urandom;
            send_request(op, key, $urandom);
         end
      end

      // Final drain: the timeout block bounds this wait.
      req_valid <= 1'b0;
      stall_pct = 0;
      @(posedge clock);
      while (replies_outstanding != 0) @(posedge clock);
      repeat (2 * ENTRIES + 8) @(posedge clock);

      $display("Summary: %0d requests sent, %0d replies checked, %0d of them hits.",
               requests_sent, replies_checked, hits_seen);
      $display("Capacities from zero to 31 were used under four idling patterns.");
      if (mismatch_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Guard against a hang: far longer than the slowest correct run needs.
   initial begin
      #5_000_000;
      $display("Timeout: %0d replies still outstanding", replies_outstanding);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
